### src/i2c_register_file_target_with_unlock_core_macros.svh
// ----------------------------------------------------------------------------
// I2C register file target - assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_FILE_TARGET_WITH_UNLOCK_CORE_MACROS_SVH
`define I2C_REGISTER_FILE_TARGET_WITH_UNLOCK_CORE_MACROS_SVH

// same-cycle implication
`define I2CRF_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define I2CRF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/i2crf_pkg.sv
// ----------------------------------------------------------------------------
// i2crf_pkg
// Types and constants shared by the I2C register file target.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2crf_pkg;

	// bus event codes
	localparam logic [1:0] OP_RX_BYTE = 2'd0;
	localparam logic [1:0] OP_READ    = 2'd1;
	localparam logic [1:0] OP_STOP    = 2'd2;

	// configuration register indexes
	localparam int         CFG_INDEX_BITS     = 1;
	localparam logic [0:0] REG_UNLOCK_FIRST   = 1'b0;
	localparam logic [0:0] REG_UNLOCK_SECOND  = 1'b1;

	localparam logic [7:0] UNLOCK_FIRST_RESET  = 8'd127;
	localparam logic [7:0] UNLOCK_SECOND_RESET = 8'd3;

	// queue between front and back
	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_PTR_BITS = 2;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_READ  = 2'd1,
		KIND_WRITE = 2'd2
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] data;
		logic       unlocked;
	} mem_op_t;

	localparam int OP_BITS = $bits(mem_op_t);

	// identification bytes preset at reset
	function automatic logic [7:0] preset_byte(input logic [15:0] idx);
		logic [7:0] val;
		case (idx)
			16'd39:  val = 8'h00;
			16'd40:  val = 8'h05;
			16'd148: val = 8'h52;
			16'd149: val = 8'h50;
			16'd150: val = 8'h30;
			16'd151: val = 8'h30;
			16'd152: val = 8'h30;
			16'd153: val = 8'h32;
			16'd166: val = 8'h52;
			16'd167: val = 8'h50;
			16'd168: val = 8'h49;
			16'd169: val = 8'h2d;
			16'd170: val = 8'h50;
			16'd171: val = 8'h49;
			16'd172: val = 8'h43;
			16'd173: val = 8'h4f;
			16'd182: val = 8'd30;
			16'd183: val = 8'd31;
			16'd184: val = 8'd32;
			16'd185: val = 8'd33;
			default: val = 8'h00;
		endcase
		return val;
	endfunction

endpackage

`default_nettype wire

### src/i2c_register_file_target_with_unlock_core.sv
// ----------------------------------------------------------------------------
// i2c_register_file_target_with_unlock_core
// I2C target back end: register memory with unlock command and auto-increment.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one bus event per transfer:
// operation (byte received, read request, stop/restart) and rx_byte.
// Output channel (out_valid/out_stall) returns exactly one result per event:
// read_data/read_valid for reads, and the unlocked flag after the event.
// Configuration: cfg_write with cfg_index/cfg_data sets the unlock byte pair.
// Each result is registered: an event passes through the operation queue and then the result register.
// Throughput: one event per cycle while in_stall is low, bounded by the single memory port.
// Reset: after arst_n releases, a preset sweep writes the identification
// bytes over all 2^ADDR_BITS memory entries, one per cycle; in_stall stays
// high until the sweep ends. Configuration writes are taken anyway.
// Output stall: the result register holds, the 4-entry operation queue
// fills, and then in_stall rises until the receiver takes results again.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_file_target_with_unlock_core #(
	parameter int ADDR_BITS = 8
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_write,
	input  wire logic [i2crf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [7:0]                           cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [1:0]                           operation,
	input  wire logic [7:0]                           rx_byte,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [7:0]                                read_data,
	output logic                                      read_valid,
	output logic                                      unlocked
);

	localparam int Q_WIDTH = i2crf_pkg::OP_BITS + ADDR_BITS;

	logic                 push, pop, q_full, q_empty, init_busy;
	i2crf_pkg::mem_op_t   push_op;
	logic [ADDR_BITS-1:0] push_addr;
	logic [Q_WIDTH-1:0]   q_head;

	i2crf_front #(.ADDR_BITS(ADDR_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.rx_byte   (rx_byte),
		.init_busy (init_busy),
		.q_full    (q_full),
		.push      (push),
		.push_op   (push_op),
		.push_addr (push_addr)
	);

	i2crf_queue #(.WIDTH(Q_WIDTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_op, push_addr}),
		.full      (q_full),
		.pop       (pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	i2crf_back #(.ADDR_BITS(ADDR_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.empty      (q_empty),
		.pop        (pop),
		.init_busy  (init_busy),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_data  (read_data),
		.read_valid (read_valid),
		.unlocked   (unlocked)
	);

endmodule

`default_nettype wire

### src/i2crf_front.sv
// ----------------------------------------------------------------------------
// i2crf_front
// Accepts bus events, tracks unlock/pointer state, issues memory operations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2crf_front #(
	parameter int ADDR_BITS = 8
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_write,
	input  wire logic [i2crf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [7:0]                           cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [1:0]                           operation,
	input  wire logic [7:0]                           rx_byte,
	input  wire logic                                 init_busy,
	input  wire logic                                 q_full,
	output logic                                      push,
	output i2crf_pkg::mem_op_t                        push_op,
	output logic [ADDR_BITS-1:0]                      push_addr
);

	logic [7:0]           first_q, second_q;
	logic [ADDR_BITS-1:0] ptr_q, ptr_d;
	logic                 loaded_q, loaded_d;
	logic [7:0]           cmd0_q, cmd0_d, cmd1_q, cmd1_d;
	logic [1:0]           count_q, count_d;
	logic                 unlock_q, unlock_d;

	assign in_stall = q_full | init_busy;
	assign push     = in_valid & ~in_stall;

	always_comb begin
		ptr_d            = ptr_q;
		loaded_d         = loaded_q;
		cmd0_d           = cmd0_q;
		cmd1_d           = cmd1_q;
		count_d          = count_q;
		unlock_d         = unlock_q;
		push_op.kind     = i2crf_pkg::KIND_NONE;
		push_op.data     = rx_byte;
		push_addr        = ptr_q;
		case (operation)
			i2crf_pkg::OP_RX_BYTE: begin
				if (!unlock_q && count_q < 2'd2) begin
					if (count_q[0]) begin
						cmd1_d = rx_byte;
					end else begin
						cmd0_d = rx_byte;
					end
					count_d = count_q + 2'd1;
				end else if (unlock_q) begin
					if (!loaded_q) begin
						ptr_d    = ADDR_BITS'(rx_byte);
						loaded_d = 1'b1;
					end else begin
						push_op.kind = i2crf_pkg::KIND_WRITE;
						ptr_d        = ptr_q + ADDR_BITS'(1);
					end
				end else begin
					ptr_d = ADDR_BITS'(rx_byte);
				end
			end
			i2crf_pkg::OP_READ: begin
				push_op.kind = i2crf_pkg::KIND_READ;
				ptr_d        = ptr_q + ADDR_BITS'(1);
			end
			i2crf_pkg::OP_STOP: begin
				if (!unlock_q && cmd0_q == first_q && cmd1_q == second_q) begin
					unlock_d = 1'b1;
					cmd0_d   = 8'h00;
					cmd1_d   = 8'h00;
				end else begin
					unlock_d = 1'b0;
				end
				count_d  = 2'd0;
				loaded_d = 1'b0;
			end
			default: begin
			end
		endcase
		push_op.unlocked = unlock_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= i2crf_pkg::UNLOCK_FIRST_RESET;
			second_q <= i2crf_pkg::UNLOCK_SECOND_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				i2crf_pkg::REG_UNLOCK_FIRST:  first_q  <= cfg_data;
				i2crf_pkg::REG_UNLOCK_SECOND: second_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			loaded_q <= 1'b0;
			cmd0_q   <= 8'h00;
			cmd1_q   <= 8'h00;
			count_q  <= 2'd0;
			unlock_q <= 1'b0;
		end else if (push) begin
			ptr_q    <= ptr_d;
			loaded_q <= loaded_d;
			cmd0_q   <= cmd0_d;
			cmd1_q   <= cmd1_d;
			count_q  <= count_d;
			unlock_q <= unlock_d;
		end
	end

endmodule

`default_nettype wire

### src/i2crf_queue.sv
// ----------------------------------------------------------------------------
// i2crf_queue
// Small FIFO of memory operations between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2crf_queue #(
	parameter int WIDTH = 19
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      head,
	output logic                  empty
);

	logic [WIDTH-1:0]                    entry_q [i2crf_pkg::QUEUE_DEPTH];
	logic [i2crf_pkg::QUEUE_PTR_BITS-1:0] wr_q, rd_q;
	logic [i2crf_pkg::QUEUE_PTR_BITS:0]   count_q;

	assign full  = count_q == (i2crf_pkg::QUEUE_PTR_BITS+1)'(i2crf_pkg::QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + (i2crf_pkg::QUEUE_PTR_BITS)'(1);
			end
			if (pop) begin
				rd_q <= rd_q + (i2crf_pkg::QUEUE_PTR_BITS)'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (i2crf_pkg::QUEUE_PTR_BITS+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (i2crf_pkg::QUEUE_PTR_BITS+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

### src/i2crf_back.sv
// ----------------------------------------------------------------------------
// i2crf_back
// Register memory, preset sweep after reset, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2crf_back #(
	parameter int ADDR_BITS = 8
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic [i2crf_pkg::OP_BITS+ADDR_BITS-1:0]  head,
	input  wire logic                                     empty,
	output logic                                          pop,
	output logic                                          init_busy,
	output logic                                          out_valid,
	input  wire logic                                     out_stall,
	output logic [7:0]                                    read_data,
	output logic                                          read_valid,
	output logic                                          unlocked
);

	localparam int DEPTH = 1 << ADDR_BITS;

	logic [7:0]           mem [DEPTH];
	i2crf_pkg::mem_op_t   head_op;
	logic [ADDR_BITS-1:0] head_addr;
	logic                 init_busy_q;
	logic [ADDR_BITS-1:0] init_addr_q;
	logic                 valid_s1, is_read_s1, unlocked_s1;
	logic [7:0]           rdata_s1;

	assign head_op   = i2crf_pkg::mem_op_t'(head[ADDR_BITS +: i2crf_pkg::OP_BITS]);
	assign head_addr = head[ADDR_BITS-1:0];
	assign init_busy = init_busy_q;
	assign pop       = ~empty & ~init_busy_q & (~valid_s1 | ~out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_busy_q <= 1'b1;
			init_addr_q <= '0;
		end else if (init_busy_q) begin
			init_addr_q <= init_addr_q + ADDR_BITS'(1);
			if (init_addr_q == '1) begin
				init_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (init_busy_q) begin
			mem[init_addr_q] <= i2crf_pkg::preset_byte(16'(init_addr_q));
		end else if (pop && head_op.kind == i2crf_pkg::KIND_WRITE) begin
			mem[head_addr] <= head_op.data;
		end
		if (pop && head_op.kind == i2crf_pkg::KIND_READ) begin
			rdata_s1 <= mem[head_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			is_read_s1  <= 1'b0;
			unlocked_s1 <= 1'b0;
		end else if (pop) begin
			valid_s1    <= 1'b1;
			is_read_s1  <= head_op.kind == i2crf_pkg::KIND_READ;
			unlocked_s1 <= head_op.unlocked;
		end else if (!out_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	assign out_valid  = valid_s1;
	assign read_valid = is_read_s1;
	assign read_data  = is_read_s1 ? rdata_s1 : 8'h00;
	assign unlocked   = unlocked_s1;

endmodule

`default_nettype wire

### src/i2crf_checker.sv
// ----------------------------------------------------------------------------
// i2crf_checker
// Port-level assertions for the I2C register file target, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_register_file_target_with_unlock_core_macros.svh"

module i2crf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] read_data,
	input wire logic       read_valid
);

	`I2CRF_ASSERT_IMPLY(a_nonread_zero, clk, arst_n, out_valid && !read_valid, read_data == 8'h00, "non-read result carries data")
	`I2CRF_ASSERT_IMPLY(a_result_follows_transfer, clk, arst_n, $rose(out_valid), $past(in_valid && !in_stall, 2), "result without input transfer")
	`I2CRF_ASSERT_NEXT(a_stall_holds, clk, arst_n, out_valid && out_stall, out_valid && $stable(read_data) && $stable(read_valid), "stalled result changed")

endmodule

bind i2c_register_file_target_with_unlock_core i2crf_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.read_data  (read_data),
	.read_valid (read_valid)
);

`default_nettype wire
